### hdl/prsgm_pkg.sv
// package for the pixel run segmenter with gap merge
// holds widths, register indexes, reset values, result types and the result builder
// no dependencies
package prsgm_pkg;

	localparam int MAX_ROW_PIXELS = 1024;
	localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
	localparam int WID_W          = COL_W + 1;
	localparam int CFG_W          = 11;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MERGE_GAP      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_WIDTH_MIN = 2'd2;

	localparam logic [CFG_W-1:0] RST_MIN_RUN_WIDTH  = 11'd5;
	localparam logic [CFG_W-1:0] RST_MERGE_GAP      = 11'd10;
	localparam logic [CFG_W-1:0] RST_WIDE_WIDTH_MIN = 11'd288;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_ROW_PIXELS - 1);

	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [CFG_W-1:0] min_run_width;
		logic [CFG_W-1:0] merge_gap;
		logic [CFG_W-1:0] wide_width_min;
	} cfg_t;

	typedef struct packed {
		logic             seg_present;
		logic [COL_W-1:0] seg_left;
		logic [COL_W-1:0] seg_right;
		logic [WID_W-1:0] seg_width;
		logic             seg_wide;
		logic             row_done;
	} result_t;

	// up to two results per pixel, a first
	typedef struct packed {
		logic [1:0] n;
		result_t    a;
		result_t    b;
	} push_t;

	function automatic result_t make_result(
		input logic             present,
		input logic [COL_W-1:0] left,
		input logic [COL_W-1:0] right,
		input logic             done,
		input logic [CFG_W-1:0] wide_min
	);
		result_t          r;
		logic [WID_W-1:0] w;
		w = {1'b0, right} - {1'b0, left} + WID_W'(1);
		r.seg_present = present;
		r.seg_left    = present ? left : '0;
		r.seg_right   = present ? right : '0;
		r.seg_width   = present ? w : '0;
		r.seg_wide    = present & (w >= wide_min);
		r.row_done    = done;
		return r;
	endfunction

endpackage

### hdl/prsgm_seg.sv
// run tracking and gap merge state, one pixel per beat
// builds up to two results per beat for the result queue; uses prsgm_pkg
module prsgm_seg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic            pixel_on,
	input  logic            row_end,
	input  prsgm_pkg::cfg_t cfg,
	output prsgm_pkg::push_t push
);
	import prsgm_pkg::*;

	logic [COL_W-1:0] column_q;
	logic             run_active_q;
	logic [COL_W-1:0] run_start_q;
	logic             pend_v_q;
	logic [COL_W-1:0] pend_l_q;
	logic [COL_W-1:0] pend_r_q;

	logic             last;
	logic             close;
	logic [COL_W-1:0] run_l;
	logic [COL_W-1:0] run_r;
	logic [WID_W-1:0] run_w;
	logic [WID_W-1:0] gap;
	logic             keep;
	logic             merge;
	logic             emit_old;
	logic             pv_t;
	logic [COL_W-1:0] pl_t;
	logic [COL_W-1:0] pr_t;
	result_t          res_old;
	result_t          res_fin;

	always_comb begin
		last     = row_end | (column_q == LAST_COL);
		close    = pixel_on ? last : run_active_q;
		run_l    = (pixel_on & ~run_active_q) ? column_q : run_start_q;
		run_r    = pixel_on ? column_q : column_q - COL_W'(1);
		run_w    = {1'b0, run_r} - {1'b0, run_l} + WID_W'(1);
		keep     = close & (run_w >= cfg.min_run_width);
		gap      = {1'b0, run_l} - {1'b0, pend_r_q};
		merge    = keep & pend_v_q & (gap <= cfg.merge_gap);
		emit_old = keep & ~merge & pend_v_q;
		pv_t     = pend_v_q | keep;
		pl_t     = (keep & ~merge) ? run_l : pend_l_q;
		pr_t     = keep ? run_r : pend_r_q;
		res_old  = make_result(1'b1, pend_l_q, pend_r_q, 1'b0, cfg.wide_width_min);
		res_fin  = make_result(pv_t, pl_t, pr_t, 1'b1, cfg.wide_width_min);
		push.a   = emit_old ? res_old : res_fin;
		push.b   = res_fin;
		if (!take) begin
			push.n = 2'd0;
		end else begin
			push.n = 2'({1'b0, emit_old} + {1'b0, last});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			run_active_q <= 1'b0;
			run_start_q  <= '0;
			pend_v_q     <= 1'b0;
			pend_l_q     <= '0;
			pend_r_q     <= '0;
		end else if (take) begin
			column_q     <= last ? '0 : column_q + COL_W'(1);
			run_active_q <= pixel_on & ~last;
			run_start_q  <= run_l;
			pend_v_q     <= pv_t & ~last;
			pend_l_q     <= pl_t;
			pend_r_q     <= pr_t;
		end
	end

endmodule

### hdl/prsgm_outq.sv
// small result queue, takes up to two results per beat and gives one per beat on pop
// uses prsgm_pkg
module prsgm_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  prsgm_pkg::push_t  push,
	input  logic              pop,
	output logic              full2,
	output logic              not_empty,
	output prsgm_pkg::result_t head
);
	import prsgm_pkg::*;

	result_t           mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign not_empty = cnt_q != '0;
	assign full2     = cnt_q > QCNT_W'(Q_DEPTH - 2);
	assign head      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.a;
		end
		if (push.n == 2'd2) begin
			mem_q[wp_q + QPTR_W'(1)] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPTR_W'(push.n);
			rp_q  <= rp_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

endmodule

### hdl/pixel_run_segmenter_gap_merge_core.sv
// a four-entry result queue registers results and stalls input when fewer than two entries
// are free; throughput: one pixel per cycle unless in_stall is high, and a row end may give
// two results, drained from the queue one per cycle unless out_stall is high
// reset: arst_n clears column, run and pending state and the queue, registers to defaults
// top level: configuration registers, segment tracker and result queue; uses prsgm_pkg
module pixel_run_segmenter_gap_merge_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            pixel_on,
	input  logic                            row_end,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            seg_present,
	output logic [prsgm_pkg::COL_W-1:0]     seg_left,
	output logic [prsgm_pkg::COL_W-1:0]     seg_right,
	output logic [prsgm_pkg::WID_W-1:0]     seg_width,
	output logic                            seg_wide,
	output logic                            row_done,
	input  logic                            cfg_we,
	input  logic [prsgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prsgm_pkg::CFG_W-1:0]     cfg_data
);
	import prsgm_pkg::*;

	cfg_t    cfg_q;
	push_t   push;
	result_t head;
	logic    full2;
	logic    take;
	logic    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_run_width  <= RST_MIN_RUN_WIDTH;
			cfg_q.merge_gap      <= RST_MERGE_GAP;
			cfg_q.wide_width_min <= RST_WIDE_WIDTH_MIN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_RUN_WIDTH:  cfg_q.min_run_width  <= cfg_data;
				REG_MERGE_GAP:      cfg_q.merge_gap      <= cfg_data;
				REG_WIDE_WIDTH_MIN: cfg_q.wide_width_min <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = full2;
	assign take     = in_valid & ~full2;
	assign pop      = out_valid & ~out_stall;

	prsgm_seg u_seg (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.pixel_on (pixel_on),
		.row_end  (row_end),
		.cfg      (cfg_q),
		.push     (push)
	);

	prsgm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.full2     (full2),
		.not_empty (out_valid),
		.head      (head)
	);

	assign seg_present = head.seg_present;
	assign seg_left    = head.seg_left;
	assign seg_right   = head.seg_right;
	assign seg_width   = head.seg_width;
	assign seg_wide    = head.seg_wide;
	assign row_done    = head.row_done;

endmodule

### hdl/prsgm_chk.sv
// port-level checks for the segmenter core, bound to the top level
// uses prsgm_pkg
module prsgm_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            pixel_on,
	input logic                            row_end,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            seg_present,
	input logic [prsgm_pkg::COL_W-1:0]     seg_left,
	input logic [prsgm_pkg::COL_W-1:0]     seg_right,
	input logic [prsgm_pkg::WID_W-1:0]     seg_width,
	input logic                            seg_wide,
	input logic                            row_done,
	input logic                            cfg_we,
	input logic [prsgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [prsgm_pkg::CFG_W-1:0]     cfg_data
);
	import prsgm_pkg::*;

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(seg_left) && $stable(seg_right)
			&& $stable(seg_present) && $stable(row_done))
		else $error("stalled result changed");

	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seg_present |->
			seg_width == ({1'b0, seg_right} - {1'b0, seg_left} + WID_W'(1)))
		else $error("segment width mismatch");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seg_present |-> seg_right >= seg_left)
		else $error("segment right before left");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seg_present |->
			row_done && seg_width == '0 && !seg_wide && seg_left == '0 && seg_right == '0)
		else $error("empty result not a clean row done");

endmodule

bind pixel_run_segmenter_gap_merge_core prsgm_chk u_prsgm_chk (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for pixel_run_segmenter_gap_merge_core
// directed table, a full-width row, then random rows checked by a segment tracking model; uses prsgm_pkg
module testbench;
	import prsgm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_BEATS  = 500;
	localparam int PHASE_BEATS   = 80;
	localparam int LAST_PHASE    = 5;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 16;
	localparam result_t ROW_DONE_EMPTY = {1'b0, {COL_W{1'b0}}, {COL_W{1'b0}}, {WID_W{1'b0}},
		1'b0, 1'b1};

	typedef enum {STEP_PIXEL, STEP_REG} step_kind_t;
	typedef struct {
		step_kind_t           kind;
		bit                   pix;
		bit                   last;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     value;
		bit                   typed;
		result_t              want;
	} step_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 pixel_on;
	logic                 row_end;
	logic                 out_valid;
	logic                 out_stall;
	logic                 seg_present;
	logic [COL_W-1:0]     seg_left;
	logic [COL_W-1:0]     seg_right;
	logic [WID_W-1:0]     seg_width;
	logic                 seg_wide;
	logic                 row_done;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// tracker copy of configuration and row state
	logic [CFG_W-1:0] min_run_cfg;
	logic [CFG_W-1:0] merge_gap_cfg;
	logic [CFG_W-1:0] wide_min_cfg;
	int               trk_column;
	bit               trk_in_run;
	int               trk_run_start;
	bit               trk_pend_valid;
	int               trk_pend_left;
	int               trk_pend_right;

	result_t want_segments[$];
	step_t   steps[$];
	int      mismatch_count;
	int      random_beats;
	bit      sender_idles;
	bit      receiver_idles;
	int      hold_requests;
	int      hold_requests_seen;
	int      hold_left;
	result_t got_seg;
	result_t want_seg;

	pixel_run_segmenter_gap_merge_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_on    (pixel_on),
		.row_end     (row_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.seg_present (seg_present),
		.seg_left    (seg_left),
		.seg_right   (seg_right),
		.seg_width   (seg_width),
		.seg_wide    (seg_wide),
		.row_done    (row_done),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic result_t seg_result(bit present, int left, int right, bit done);
		result_t r;
		int      w;
		r = '0;
		w = right - left + 1;
		if (present) begin
			r.seg_present = 1'b1;
			r.seg_left    = COL_W'(left);
			r.seg_right   = COL_W'(right);
			r.seg_width   = WID_W'(w);
			r.seg_wide    = (w >= int'(wide_min_cfg));
		end
		r.row_done = done;
		return r;
	endfunction

	task automatic offer_run(input int left, input int right, inout int n,
		inout result_t r0, inout result_t r1);
		if (right - left + 1 < int'(min_run_cfg))
			return;
		if (trk_pend_valid && (left - trk_pend_right) <= int'(merge_gap_cfg)) begin
			trk_pend_right = right;
			return;
		end
		if (trk_pend_valid) begin
			r0 = seg_result(1'b1, trk_pend_left, trk_pend_right, 1'b0);
			n  = 1;
		end
		trk_pend_valid = 1'b1;
		trk_pend_left  = left;
		trk_pend_right = right;
	endtask

	task automatic track_pixel(input bit pix, input bit last, output int n,
		output result_t r0, output result_t r1);
		int col;
		bit end_of_row;
		n  = 0;
		r0 = '0;
		r1 = '0;
		col = trk_column;
		end_of_row = last || (col >= MAX_ROW_PIXELS - 1);
		if (pix) begin
			if (!trk_in_run) begin
				trk_in_run    = 1'b1;
				trk_run_start = col;
			end
			if (end_of_row) begin
				offer_run(trk_run_start, col, n, r0, r1);
				trk_in_run = 1'b0;
			end
		end else if (trk_in_run) begin
			offer_run(trk_run_start, col - 1, n, r0, r1);
			trk_in_run = 1'b0;
		end
		if (end_of_row) begin
			if (n == 0)
				r0 = seg_result(trk_pend_valid, trk_pend_left, trk_pend_right, 1'b1);
			else
				r1 = seg_result(trk_pend_valid, trk_pend_left, trk_pend_right, 1'b1);
			n++;
			trk_pend_valid = 1'b0;
			trk_in_run     = 1'b0;
			trk_column     = 0;
		end else begin
			trk_column = col + 1;
		end
	endtask

	task automatic send_beat(input bit pix, input bit last, input bit typed, input result_t want);
		int      n;
		result_t r0;
		result_t r1;
		@(negedge clk);
		while (sender_idles && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_on <= pix;
		row_end  <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_pixel(pix, last, n, r0, r1);
		if (typed) begin
			want_segments.insert(want_segments.size(), want);
		end else begin
			if (n >= 1)
				want_segments.insert(want_segments.size(), r0);
			if (n == 2)
				want_segments.insert(want_segments.size(), r1);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (want_segments.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_MIN_RUN_WIDTH:  min_run_cfg = val;
			REG_MERGE_GAP:      merge_gap_cfg = val;
			REG_WIDE_WIDTH_MIN: wide_min_cfg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input int min_run, input int gap, input int wide_min);
		wait_idle();
		write_reg(REG_MIN_RUN_WIDTH, CFG_W'(min_run));
		write_reg(REG_MERGE_GAP, CFG_W'(gap));
		write_reg(REG_WIDE_WIDTH_MIN, CFG_W'(wide_min));
	endtask

	task automatic pix_step(input bit pix, input bit last);
		step_t s;
		s = '{STEP_PIXEL, pix, last, '0, '0, 1'b0, '0};
		steps.insert(steps.size(), s);
	endtask

	task automatic empty_step(input bit pix, input bit last);
		step_t s;
		s = '{STEP_PIXEL, pix, last, '0, '0, 1'b1, ROW_DONE_EMPTY};
		steps.insert(steps.size(), s);
	endtask

	task automatic reg_step(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		step_t s;
		s = '{STEP_REG, 1'b0, 1'b0, idx, val, 1'b0, '0};
		steps.insert(steps.size(), s);
	endtask

	function automatic int pick_min();
		case ($urandom_range(0, 10))
			0: return 0;
			1, 2: return 1;
			3: return 2;
			4: return 3;
			5: return 5;
			6: return 8;
			7: return 1024;
			8: return 2047;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic int pick_gap();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 2;
			3: return 3;
			4: return 5;
			5: return 10;
			6: return 1024;
			7: return 2047;
			default: return $urandom_range(0, 20);
		endcase
	endfunction

	function automatic int pick_wide();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 3;
			3: return 6;
			4: return 12;
			5: return 20;
			6: return 1024;
			7: return 2047;
			default: return $urandom_range(0, 30);
		endcase
	endfunction

	// runs and gaps sized around the current thresholds, some rows pure noise
	task automatic random_row(output int beats);
		int len;
		int col;
		int seg;
		int k;
		int run_cap;
		int gap_cap;
		bit level;
		bit noise;
		bit pix;
		bit last;
		run_cap = int'(min_run_cfg) + 3;
		gap_cap = int'(merge_gap_cfg) + 3;
		if (run_cap > 24) run_cap = 24;
		if (gap_cap > 24) gap_cap = 24;
		len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 80);
		noise = ($urandom_range(0, 9) == 0);
		level = $urandom_range(0, 1);
		col   = 0;
		while (col < len) begin
			seg = level ? $urandom_range(1, run_cap) : $urandom_range(1, gap_cap);
			for (k = 0; k < seg && col < len; k++) begin
				pix  = noise ? 1'($urandom_range(0, 1)) : level;
				last = (col == len - 1);
				if (noise && $urandom_range(0, 7) == 0)
					last = ~last;
				send_beat(pix, last, 1'b0, '0);
				col++;
			end
			level = ~level;
		end
		beats = len;
	endtask

	always @(negedge clk) begin
		if (hold_requests != hold_requests_seen) begin
			hold_requests_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= receiver_idles && ($urandom_range(0, 99) < 27);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_seg.seg_present = seg_present;
			got_seg.seg_left    = seg_left;
			got_seg.seg_right   = seg_right;
			got_seg.seg_width   = seg_width;
			got_seg.seg_wide    = seg_wide;
			got_seg.row_done    = row_done;
			if (want_segments.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected beat: present=%0d left=%0d right=%0d width=%0d wide=%0d done=%0d",
						got_seg.seg_present, got_seg.seg_left, got_seg.seg_right,
						got_seg.seg_width, got_seg.seg_wide, got_seg.row_done);
			end else begin
				want_seg = want_segments.pop_front();
				if (got_seg.seg_present !== want_seg.seg_present
					|| got_seg.seg_left !== want_seg.seg_left
					|| got_seg.seg_right !== want_seg.seg_right
					|| got_seg.seg_width !== want_seg.seg_width
					|| got_seg.seg_wide !== want_seg.seg_wide
					|| got_seg.row_done !== want_seg.row_done) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: want %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
							want_seg.seg_present, want_seg.seg_left, want_seg.seg_right,
							want_seg.seg_width, want_seg.seg_wide, want_seg.row_done,
							got_seg.seg_present, got_seg.seg_left, got_seg.seg_right,
							got_seg.seg_width, got_seg.seg_wide, got_seg.row_done);
				end
			end
		end
	end

	initial begin
		int i;
		int phase;
		int phase_beats;
		int beats;
		bit paused;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		pixel_on       = 1'b0;
		row_end        = 1'b0;
		out_stall      = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		min_run_cfg    = RST_MIN_RUN_WIDTH;
		merge_gap_cfg  = RST_MERGE_GAP;
		wide_min_cfg   = RST_WIDE_WIDTH_MIN;
		trk_column     = 0;
		trk_in_run     = 1'b0;
		trk_run_start  = 0;
		trk_pend_valid = 1'b0;
		trk_pend_left  = 0;
		trk_pend_right = 0;
		mismatch_count = 0;
		random_beats   = 0;
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		hold_requests      = 0;
		hold_requests_seen = 0;
		hold_left          = 0;

		// directed rows
		empty_step(1'b0, 1'b1);
		empty_step(1'b1, 1'b1);
		reg_step(REG_MIN_RUN_WIDTH, 11'd2);
		reg_step(REG_MERGE_GAP, 11'd2);
		reg_step(REG_WIDE_WIDTH_MIN, 11'd5);
		// gap exactly at the limit merges
		pix_step(1'b1, 1'b0);
		pix_step(1'b1, 1'b0);
		pix_step(1'b0, 1'b0);
		pix_step(1'b1, 1'b0);
		pix_step(1'b1, 1'b1);
		// one past the limit gives two results at row end
		reg_step(REG_MERGE_GAP, 11'd1);
		pix_step(1'b1, 1'b0);
		pix_step(1'b1, 1'b0);
		pix_step(1'b0, 1'b0);
		pix_step(1'b1, 1'b0);
		pix_step(1'b1, 1'b1);
		reg_step(REG_MIN_RUN_WIDTH, 11'd0);
		reg_step(REG_WIDE_WIDTH_MIN, 11'd0);
		pix_step(1'b1, 1'b0);
		pix_step(1'b0, 1'b0);
		pix_step(1'b1, 1'b1);
		reg_step(REG_UNUSED, 11'h7ff);
		reg_step(REG_MIN_RUN_WIDTH, 11'h7ff);
		pix_step(1'b1, 1'b0);
		empty_step(1'b1, 1'b1);
		reg_step(REG_MIN_RUN_WIDTH, 11'd2);
		reg_step(REG_MERGE_GAP, 11'd0);
		reg_step(REG_WIDE_WIDTH_MIN, 11'd2);
		pix_step(1'b1, 1'b0);
		pix_step(1'b1, 1'b0);
		pix_step(1'b0, 1'b1);
		pix_step(1'b0, 1'b0);
		empty_step(1'b1, 1'b1);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < steps.size(); i++) begin
			if (steps[i].kind == STEP_REG) begin
				wait_idle();
				write_reg(steps[i].idx, steps[i].value);
			end else begin
				send_beat(steps[i].pix, steps[i].last, steps[i].typed, steps[i].want);
			end
		end

		// full-width row of set pixels, ended by the column limit
		set_regs(1024, 0, 1024);
		for (i = 0; i < MAX_ROW_PIXELS; i++)
			send_beat(1'b1, 1'b0, 1'b0, '0);

		phase = 0;
		while (random_beats < RANDOM_BEATS || phase <= LAST_PHASE) begin
			set_regs(pick_min(), pick_gap(), pick_wide());
			if (phase == 1) begin
				sender_idles   = 1'b0;
				receiver_idles = 1'b0;
			end
			if (phase == 3)
				hold_requests++;
			phase_beats = 0;
			paused = 1'b0;
			while (phase_beats < PHASE_BEATS) begin
				random_row(beats);
				phase_beats += beats;
				random_beats += beats;
				if (phase == 5 && !paused && phase_beats > PHASE_BEATS / 2) begin
					wait_idle();
					paused = 1'b1;
				end
			end
			sender_idles   = 1'b1;
			receiver_idles = 1'b1;
			phase++;
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && want_segments.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
hdl/prsgm_pkg.sv
hdl/prsgm_seg.sv
hdl/prsgm_outq.sv
hdl/pixel_run_segmenter_gap_merge_core.sv
hdl/prsgm_chk.sv
tb/sv/testbench.sv
